FILE: src/hpd_pkg.sv
package hpd_pkg;

  localparam int unsigned MaxFolds = 8;
  localparam int unsigned Faces    = 6;
  localparam int unsigned FoldCntW = $clog2(MaxFolds + 1);

  localparam int unsigned InW     = 24;
  localparam int unsigned CompW   = 25;
  localparam int unsigned FdW     = 23;
  localparam int unsigned NormW   = 16;
  localparam int unsigned ProdW   = CompW + NormW;
  localparam int unsigned ProjW   = ProdW + 1;
  localparam int unsigned LimitW  = FdW + 14;
  localparam int unsigned FaceW   = 3;
  localparam int unsigned SumW    = 52;
  localparam int unsigned RootW   = SumW / 2;
  localparam int unsigned SepW    = 25;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;

  // compare chain registers: product, projection, one pick register per face cell
  localparam int unsigned PickLat = 2 + Faces;

  localparam logic [CfgIdxW-1:0] RegPeriodic = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFaceDist = 3'd1;

  localparam logic [FaceW-1:0] FaceNone = 3'd0;

  typedef struct packed {
    logic signed [ProjW-1:0] best;
    logic [FaceW-1:0]        face;
  } pick_t;

endpackage

FILE: src/hex_periodic_distance_core.sv
// Channel  | Direction | Ports                                              | Handshake
// ---------+-----------+----------------------------------------------------+------------------
// command  | in        | first_x/y/z_i, second_x/y/z_i                      | start_i, !busy_o
// result   | out       | separation_o, last_face_o, fold_limit_hit_o        | done_o strobe
// config   | in        | cfg_index_i, cfg_data_i                            | cfg_valid_i/ready_o
//
// One item at a time. Each fold pass lets the compare chain through the six face cells
// settle, then applies the fold in a multiply and an add step; up to 8 folds plus a final
// test. The length is found by squaring, summing and a bit-serial square root with a
// rounding step.
// Reset is asynchronous, active low, and clears the configuration and control state.
// Results cannot be stalled: done_o is high for exactly one cycle per item.
module hex_periodic_distance_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [hpd_pkg::InW-1:0]     first_x_i,
  input  logic signed [hpd_pkg::InW-1:0]     first_y_i,
  input  logic signed [hpd_pkg::InW-1:0]     first_z_i,
  input  logic signed [hpd_pkg::InW-1:0]     second_x_i,
  input  logic signed [hpd_pkg::InW-1:0]     second_y_i,
  input  logic signed [hpd_pkg::InW-1:0]     second_z_i,
  output logic                               done_o,
  output logic [hpd_pkg::SepW-1:0]           separation_o,
  output logic [hpd_pkg::FaceW-1:0]          last_face_o,
  output logic                               fold_limit_hit_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hpd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [hpd_pkg::CfgW-1:0]           cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PICK, ST_FOLD_MUL, ST_FOLD_ADD, ST_SQUARE, ST_SUM, ST_ROOT_GO, ST_ROOT_WAIT
  } state_e;

  localparam int unsigned PickCntW = $clog2(hpd_pkg::PickLat + 1);
  localparam int unsigned StepW    = hpd_pkg::FdW + 1 + hpd_pkg::NormW;
  localparam int unsigned RndW     = StepW - 14;
  localparam int unsigned DiffW    = RndW + 1;
  localparam int unsigned SqW      = 2 * hpd_pkg::CompW;

  // configuration
  logic                           periodic_q;
  logic [hpd_pkg::FdW-1:0]        fd_q;
  logic [hpd_pkg::CfgW-1:0]       normal_q [hpd_pkg::Faces];

  state_e                         state_q;
  logic signed [hpd_pkg::CompW-1:0] dx_q, dy_q, dz_q;
  logic [hpd_pkg::FoldCntW-1:0]   nfold_q;
  logic [PickCntW-1:0]            pcnt_q;
  logic [hpd_pkg::FaceW-1:0]      last_q;
  logic [hpd_pkg::FaceW-1:0]      face_q;
  logic                           hit_q;
  logic signed [StepW-1:0]        stepx_q, stepy_q;
  logic signed [SqW-1:0]          sqx_q, sqy_q, sqz_q;
  logic [hpd_pkg::SumW-1:0]       sum_q;
  logic                           done_q;
  logic [hpd_pkg::SepW-1:0]       sep_q;
  logic [hpd_pkg::FaceW-1:0]      face_out_q;
  logic                           hit_out_q;

  logic [hpd_pkg::LimitW-1:0]     limit;
  hpd_pkg::pick_t                 chain [hpd_pkg::Faces+1];
  logic [hpd_pkg::CfgW-1:0]       sel_normal;
  logic signed [hpd_pkg::NormW-1:0] sel_nx, sel_ny;
  logic signed [hpd_pkg::FdW+1:0] twice;
  logic signed [RndW-1:0]         rndx, rndy;
  logic signed [DiffW-1:0]        newx, newy;
  logic signed [hpd_pkg::CompW-1:0] satx, sety;
  logic                           sq_start, sq_done;
  logic [hpd_pkg::SepW-1:0]       sq_root;
  hpd_pkg::pick_t                 result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periodic_q <= 1'b0;
      fd_q       <= '0;
      for (int i = 0; i < hpd_pkg::Faces; i++) normal_q[i] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hpd_pkg::RegPeriodic: periodic_q <= cfg_data_i[0];
        hpd_pkg::RegFaceDist: fd_q       <= cfg_data_i[hpd_pkg::FdW-1:0];
        default: normal_q[cfg_index_i - 3'd2] <= cfg_data_i;
      endcase
    end
  end

  // face cell chain: best crossed projection ripples one cell per cycle
  assign limit           = {fd_q, 14'd0};
  assign chain[0].best   = '0;
  assign chain[0].face   = hpd_pkg::FaceNone;

  for (genvar g = 0; g < hpd_pkg::Faces; g++) begin : g_cell
    hpd_face_cell u_cell (
      .clk_i     (clk_i),
      .dx_i      (dx_q),
      .dy_i      (dy_q),
      .normal_i  (normal_q[g]),
      .limit_i   (limit),
      .face_id_i (hpd_pkg::FaceW'(g + 1)),
      .pick_i    (chain[g]),
      .pick_o    (chain[g+1])
    );
  end

  assign result = chain[hpd_pkg::Faces];

  // fold step: 2*d*n in Q.14, rounded half up to Q.0, then saturate
  assign sel_normal = normal_q[face_q - 3'd1];
  assign sel_nx     = sel_normal[31:16];
  assign sel_ny     = sel_normal[15:0];
  assign twice      = signed'({1'b0, fd_q, 1'b0});
  assign rndx       = RndW'((stepx_q + StepW'(8192)) >>> 14);
  assign rndy       = RndW'((stepy_q + StepW'(8192)) >>> 14);
  assign newx       = DiffW'(dx_q) - DiffW'(rndx);
  assign newy       = DiffW'(dy_q) - DiffW'(rndy);

  function automatic logic signed [hpd_pkg::CompW-1:0] sat(input logic signed [DiffW-1:0] v);
    logic signed [DiffW-1:0] hi, lo;
    hi = DiffW'(2 ** (hpd_pkg::CompW - 1) - 1);
    lo = -DiffW'(2 ** (hpd_pkg::CompW - 1));
    if (v > hi) return hi[hpd_pkg::CompW-1:0];
    if (v < lo) return lo[hpd_pkg::CompW-1:0];
    return v[hpd_pkg::CompW-1:0];
  endfunction

  assign satx = sat(newx);
  assign sety = sat(newy);

  always_ff @(posedge clk_i) begin
    stepx_q <= StepW'(twice * sel_nx);
    stepy_q <= StepW'(twice * sel_ny);
    sqx_q   <= dx_q * dx_q;
    sqy_q   <= dy_q * dy_q;
    sqz_q   <= dz_q * dz_q;
    sum_q   <= hpd_pkg::SumW'(unsigned'(sqx_q)) + hpd_pkg::SumW'(unsigned'(sqy_q))
             + hpd_pkg::SumW'(unsigned'(sqz_q));
  end

  assign sq_start = (state_q == ST_ROOT_GO);

  hpd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sum_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      done_q     <= 1'b0;
      nfold_q    <= '0;
      pcnt_q     <= '0;
      last_q     <= hpd_pkg::FaceNone;
      face_q     <= hpd_pkg::FaceNone;
      hit_q      <= 1'b0;
      sep_q      <= '0;
      face_out_q <= hpd_pkg::FaceNone;
      hit_out_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            dx_q    <= hpd_pkg::CompW'(first_x_i) - hpd_pkg::CompW'(second_x_i);
            dy_q    <= hpd_pkg::CompW'(first_y_i) - hpd_pkg::CompW'(second_y_i);
            dz_q    <= hpd_pkg::CompW'(first_z_i) - hpd_pkg::CompW'(second_z_i);
            nfold_q <= '0;
            pcnt_q  <= '0;
            last_q  <= hpd_pkg::FaceNone;
            hit_q   <= 1'b0;
            state_q <= periodic_q ? ST_PICK : ST_SQUARE;
          end
        end
        ST_PICK: begin
          if (pcnt_q == PickCntW'(hpd_pkg::PickLat)) begin
            if (result.face == hpd_pkg::FaceNone) begin
              state_q <= ST_SQUARE;
            end else if (nfold_q == hpd_pkg::FoldCntW'(hpd_pkg::MaxFolds)) begin
              hit_q   <= 1'b1;
              state_q <= ST_SQUARE;
            end else begin
              face_q  <= result.face;
              state_q <= ST_FOLD_MUL;
            end
          end else begin
            pcnt_q <= pcnt_q + 1'b1;
          end
        end
        ST_FOLD_MUL: state_q <= ST_FOLD_ADD;
        ST_FOLD_ADD: begin
          dx_q    <= satx;
          dy_q    <= sety;
          last_q  <= face_q;
          nfold_q <= nfold_q + 1'b1;
          pcnt_q  <= '0;
          state_q <= ST_PICK;
        end
        ST_SQUARE:  state_q <= ST_SUM;
        ST_SUM:     state_q <= ST_ROOT_GO;
        ST_ROOT_GO: state_q <= ST_ROOT_WAIT;
        ST_ROOT_WAIT: begin
          if (sq_done) begin
            sep_q      <= sq_root;
            face_out_q <= last_q;
            hit_out_q  <= hit_q;
            done_q     <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign separation_o     = sep_q;
  assign last_face_o      = face_out_q;
  assign fold_limit_hit_o = hit_out_q;

endmodule

FILE: src/hpd_face_cell.sv
module hpd_face_cell (
  input  logic                             clk_i,
  input  logic signed [hpd_pkg::CompW-1:0] dx_i,
  input  logic signed [hpd_pkg::CompW-1:0] dy_i,
  input  logic [hpd_pkg::CfgW-1:0]         normal_i,
  input  logic [hpd_pkg::LimitW-1:0]       limit_i,
  input  logic [hpd_pkg::FaceW-1:0]        face_id_i,
  input  hpd_pkg::pick_t                   pick_i,
  output hpd_pkg::pick_t                   pick_o
);

  logic signed [hpd_pkg::NormW-1:0] nx, ny;
  logic signed [hpd_pkg::ProdW-1:0] px_q, py_q;
  logic signed [hpd_pkg::ProjW-1:0] proj_q;
  logic signed [hpd_pkg::ProjW-1:0] limit_s;
  hpd_pkg::pick_t                   pick_q;
  logic                             take;

  assign nx      = normal_i[31:16];
  assign ny      = normal_i[15:0];
  assign limit_s = signed'({{(hpd_pkg::ProjW-hpd_pkg::LimitW){1'b0}}, limit_i});
  assign take    = (proj_q > limit_s) && (proj_q > pick_i.best);

  always_ff @(posedge clk_i) begin
    px_q   <= hpd_pkg::ProdW'(dx_i * nx);
    py_q   <= hpd_pkg::ProdW'(dy_i * ny);
    proj_q <= hpd_pkg::ProjW'(px_q) + hpd_pkg::ProjW'(py_q);
    if (take) begin
      pick_q.best <= proj_q;
      pick_q.face <= face_id_i;
    end else begin
      pick_q <= pick_i;
    end
  end

  assign pick_o = pick_q;

endmodule

FILE: src/hpd_sqrt.sv
module hpd_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [hpd_pkg::SumW-1:0]   value_i,
  output logic                       done_o,
  output logic [hpd_pkg::SepW-1:0]   root_o
);

  typedef enum logic [1:0] {SQ_IDLE, SQ_RUN, SQ_ROUND} sq_state_e;

  localparam int unsigned RemW = hpd_pkg::RootW + 1;
  localparam int unsigned CntW = $clog2(hpd_pkg::RootW + 1);

  sq_state_e                  state_q;
  logic [hpd_pkg::SumW-1:0]   v_q;
  logic [RemW-1:0]            rem_q;
  logic [hpd_pkg::RootW-1:0]  root_q;
  logic [CntW-1:0]            cnt_q;
  logic                       done_q;
  logic [RemW+1:0]            rem_sh;
  logic [RemW+1:0]            trial;
  logic                       fits;

  assign rem_sh = {rem_q, v_q[hpd_pkg::SumW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        SQ_IDLE: begin
          if (start_i) begin
            v_q     <= value_i;
            rem_q   <= '0;
            root_q  <= '0;
            cnt_q   <= CntW'(hpd_pkg::RootW);
            state_q <= SQ_RUN;
          end
        end
        SQ_RUN: begin
          // one result bit per cycle, two radicand bits consumed
          v_q <= {v_q[hpd_pkg::SumW-3:0], 2'b00};
          if (fits) begin
            rem_q  <= RemW'(rem_sh - trial);
            root_q <= {root_q[hpd_pkg::RootW-2:0], 1'b1};
          end else begin
            rem_q  <= RemW'(rem_sh);
            root_q <= {root_q[hpd_pkg::RootW-2:0], 1'b0};
          end
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CntW'(1)) state_q <= SQ_ROUND;
        end
        SQ_ROUND: begin
          // round to nearest: bump when remainder exceeds root
          if (rem_q > {1'b0, root_q}) root_q <= root_q + 1'b1;
          done_q  <= 1'b1;
          state_q <= SQ_IDLE;
        end
        default: state_q <= SQ_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign root_o = root_q[hpd_pkg::SepW-1:0];

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned DrainCycles = 200;
  localparam logic [hpd_pkg::CfgIdxW-1:0] RegNormalBase = 3'd2;

  typedef struct {
    logic [hpd_pkg::SepW-1:0]  separation;
    logic [hpd_pkg::FaceW-1:0] last_face;
    logic                      fold_limit_hit;
  } dist_res_t;

  class dist_scoreboard;
    logic                     periodic_on;
    logic [hpd_pkg::FdW-1:0]  face_dist;
    logic [hpd_pkg::CfgW-1:0] normals[hpd_pkg::Faces];
    dist_res_t                pending[$];
    int                       errors;

    function new();
      periodic_on = 1'b0;
      face_dist = '0;
      foreach (normals[f]) normals[f] = '0;
      errors = 0;
    endfunction

    function void note_config(logic [hpd_pkg::CfgIdxW-1:0] idx, logic [hpd_pkg::CfgW-1:0] data);
      if (idx == hpd_pkg::RegPeriodic) periodic_on = data[0];
      else if (idx == hpd_pkg::RegFaceDist) face_dist = data[hpd_pkg::FdW-1:0];
      else if (idx >= RegNormalBase && idx < RegNormalBase + hpd_pkg::Faces)
        normals[idx - RegNormalBase] = data;
    endfunction

    function longint norm_x(int f);
      return longint'($signed(normals[f][31:16]));
    endfunction

    function longint norm_y(int f);
      return longint'($signed(normals[f][15:0]));
    endfunction

    function int crossed_face(longint dx, longint dy);
      longint lim, best, p;
      int face;
      lim = longint'(face_dist) <<< 14;
      best = 0;
      face = 0;
      for (int f = 0; f < hpd_pkg::Faces; f++) begin
        p = dx * norm_x(f) + dy * norm_y(f);
        if (p > lim && p > best) begin
          best = p;
          face = f + 1;
        end
      end
      return face;
    endfunction

    function longint round_fold(longint v);
      if (v >= 0) return (v + 8192) >>> 14;
      return -((-v + 8191) >>> 14);
    endfunction

    function longint clamp(longint v);
      if (v > 16777215) return 16777215;
      if (v < -16777216) return -16777216;
      return v;
    endfunction

    function longint unsigned isqrt_round(longint unsigned v);
      longint unsigned r, bitv, n;
      r = 0;
      bitv = 64'd1 << 62;
      n = v;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= r + bitv) begin
          n -= r + bitv;
          r = (r >> 1) + bitv;
        end else begin
          r >>= 1;
        end
        bitv >>= 2;
      end
      if (r * r + r < v) r++;
      return r;
    endfunction

    function void note_input(logic signed [hpd_pkg::InW-1:0] ax,
                             logic signed [hpd_pkg::InW-1:0] ay,
                             logic signed [hpd_pkg::InW-1:0] az,
                             logic signed [hpd_pkg::InW-1:0] bx,
                             logic signed [hpd_pkg::InW-1:0] by,
                             logic signed [hpd_pkg::InW-1:0] bz);
      longint dx, dy, dz, twice;
      longint unsigned sum;
      int face, n;
      dist_res_t r;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      dz = longint'(az) - longint'(bz);
      r.last_face = hpd_pkg::FaceNone;
      r.fold_limit_hit = 1'b0;
      if (periodic_on) begin
        twice = 2 * longint'(face_dist);
        for (n = 0; n < hpd_pkg::MaxFolds; n++) begin
          face = crossed_face(dx, dy);
          if (face == 0) break;
          dx = clamp(dx - round_fold(twice * norm_x(face - 1)));
          dy = clamp(dy - round_fold(twice * norm_y(face - 1)));
          r.last_face = hpd_pkg::FaceW'(face);
        end
        if (n == hpd_pkg::MaxFolds && crossed_face(dx, dy) != 0) r.fold_limit_hit = 1'b1;
      end
      sum = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
      r.separation = hpd_pkg::SepW'(isqrt_round(sum));
      pending.push_back(r);
    endfunction

    function void check_result(logic [hpd_pkg::SepW-1:0] sep, logic [hpd_pkg::FaceW-1:0] lf,
                               logic hit);
      dist_res_t e;
      if (pending.size() == 0) begin
        $error("result with no pending prediction");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (sep !== e.separation) begin
        $error("separation exp %0d got %0d", e.separation, sep);
        errors++;
      end
      if (lf !== e.last_face) begin
        $error("last_face exp %0d got %0d", e.last_face, lf);
        errors++;
      end
      if (hit !== e.fold_limit_hit) begin
        $error("fold_limit_hit exp %0d got %0d", e.fold_limit_hit, hit);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, start_i, busy_o, done_o, fold_limit_hit_o;
  logic signed [hpd_pkg::InW-1:0] first_x_i, first_y_i, first_z_i;
  logic signed [hpd_pkg::InW-1:0] second_x_i, second_y_i, second_z_i;
  logic [hpd_pkg::SepW-1:0] separation_o;
  logic [hpd_pkg::FaceW-1:0] last_face_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [hpd_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [hpd_pkg::CfgW-1:0] cfg_data_i;

  dist_scoreboard sb;
  int idle_cycles;
  int send_idle_pct;

  hex_periodic_distance_core i_dut (.*);

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done_o) sb.check_result(separation_o, last_face_o, fold_limit_hit_o);
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [hpd_pkg::CfgIdxW-1:0] idx, logic [hpd_pkg::CfgW-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.note_config(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // drain before any register write so the block is idle
  task automatic wait_drained();
    while (sb.pending.size() != 0 || busy_o) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_hexagon(logic periodic, logic [hpd_pkg::FdW-1:0] fd, bit garbage);
    // unit normals at 0,60,...,300 degrees in Q1.14
    logic [hpd_pkg::CfgW-1:0] hex_n[hpd_pkg::Faces];
    hex_n = '{{16'sd16384, 16'sd0}, {16'sd8192, 16'sd14189}, {-16'sd8192, 16'sd14189},
              {-16'sd16384, 16'sd0}, {-16'sd8192, -16'sd14189}, {16'sd8192, -16'sd14189}};
    wait_drained();
    write_reg(hpd_pkg::RegPeriodic, {31'($urandom), periodic});
    write_reg(hpd_pkg::RegFaceDist, {9'($urandom), fd});
    for (int f = 0; f < hpd_pkg::Faces; f++)
      write_reg(hpd_pkg::CfgIdxW'(int'(RegNormalBase) + f),
                garbage ? hpd_pkg::CfgW'($urandom) : hex_n[f]);
  endtask

  task automatic send_pair(logic signed [hpd_pkg::InW-1:0] ax,
                           logic signed [hpd_pkg::InW-1:0] ay,
                           logic signed [hpd_pkg::InW-1:0] az,
                           logic signed [hpd_pkg::InW-1:0] bx,
                           logic signed [hpd_pkg::InW-1:0] by,
                           logic signed [hpd_pkg::InW-1:0] bz);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    first_x_i <= ax; first_y_i <= ay; first_z_i <= az;
    second_x_i <= bx; second_y_i <= by; second_z_i <= bz;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    sb.note_input(ax, ay, az, bx, by, bz);
    @(negedge clk_i);
    start_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic signed [hpd_pkg::InW-1:0] rand_coord(logic [hpd_pkg::FdW-1:0] fd);
    case ($urandom_range(3))
      0: return hpd_pkg::InW'($urandom);
      1: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      default: return hpd_pkg::InW'($signed(hpd_pkg::InW'($urandom_range(4 * fd + 16)))
                                    - 2 * fd - 8);
    endcase
  endfunction

  task automatic random_batch(int count, logic [hpd_pkg::FdW-1:0] fd);
    for (int k = 0; k < count; k++)
      send_pair(rand_coord(fd), rand_coord(fd), hpd_pkg::InW'($urandom),
                rand_coord(fd), rand_coord(fd), hpd_pkg::InW'($urandom));
  endtask

  localparam logic signed [hpd_pkg::InW-1:0] PMax = 24'sh7FFFFF;
  localparam logic signed [hpd_pkg::InW-1:0] PMin = 24'sh800000;
  localparam logic signed [hpd_pkg::InW-1:0] PZero = 24'sd0;

  initial begin
    sb = new();
    idle_cycles = 0;
    send_idle_pct = 25;
    rst_ni = 1'b0;
    start_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    {first_x_i, first_y_i, first_z_i, second_x_i, second_y_i, second_z_i} = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // plain length at reset settings, extreme coordinates
    send_pair(PZero, PZero, PZero, PZero, PZero, PZero);
    send_pair(PMax, PMax, PMax, PMin, PMin, PMin);
    send_pair(PMin, PMin, PMin, PMax, PMax, PMax);
    send_pair(PMax, PZero, PZero, PZero, PZero, PZero);
    send_pair(-24'sd1, -24'sd1, -24'sd1, PZero, PZero, PZero);

    // zero face distance: any positive projection crosses
    set_hexagon(1'b1, '0, 1'b0);
    send_pair(24'sd4096, PZero, PZero, PZero, PZero, PZero);
    send_pair(PZero, 24'sd4096, 24'sd7, PZero, PZero, PZero);
    send_pair(PZero, PZero, PZero, PZero, PZero, PZero);

    // folding cases, then beyond the fold bound
    set_hexagon(1'b1, 23'd4096, 1'b0);
    send_pair(24'sd12288, PZero, PZero, PZero, PZero, PZero);
    send_pair(24'sd8192, 24'sd14189, PZero, PZero, PZero, PZero);
    send_pair(24'sd4000, PZero, PZero, PZero, PZero, PZero);
    send_pair(PMax, PMax, PZero, PMin, PMin, PZero);
    send_pair(PMin, PZero, PMax, PMax, PZero, PMin);

    set_hexagon(1'b1, 23'h7FFFFF, 1'b0);
    send_pair(PMax, PMax, PZero, PMin, PMin, PZero);
    send_pair(PMin, PMax, PZero, PMax, PMin, PZero);

    set_hexagon(1'b1, 23'd20000, 1'b1);
    send_pair(PMax, 24'sd1234, PZero, PMin, -24'sd999, PZero);
    send_pair(24'sd50000, -24'sd70000, PZero, PZero, PZero, PZero);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 71 : 0;
      set_hexagon(1'b1, 23'($urandom_range(65535)), 1'b0);
      random_batch(150, 23'd40000);
      set_hexagon(1'b0, 23'($urandom), 1'b1);
      random_batch(60, 23'd40000);
      set_hexagon(1'b1, 23'($urandom), 1'b0);
      random_batch(80, 23'h7FFFFF);
      set_hexagon(1'b1, 23'($urandom_range(4096)), 1'b1);
      random_batch(60, 23'd8192);
      wait_drained();
      set_hexagon(1'b1, 23'($urandom_range(20000)), 1'b0);
      random_batch(100, 23'd20000);
    end

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/hpd_pkg.sv
src/hpd_face_cell.sv
src/hpd_sqrt.sv
src/hex_periodic_distance_core.sv
tb/sv/tb_top.sv
